// ===== rtl/psc_pkg.sv =====
package psc_pkg;

	localparam int PATH_POINTS = 4096;
	localparam int AW = $clog2(PATH_POINTS);
	localparam int SEARCH_HALF_WINDOW = 500;
	localparam int MEM_W = 48 + 48 + 19 + 19;

	localparam int PI_Q16 = 205887;
	localparam int TWO_PI_Q16 = 411775;
	localparam int HALF_PI_Q16 = 102944;
	localparam int DEG2RAD_Q32 = 74961321;
	localparam int RAD2DEG_Q16 = 3754936;
	localparam int TRIM_RAD_Q16 = 3431;
	localparam int TRIM_DEG_Q16 = 196608;
	localparam int TORQUE_LIMIT = 327680;
	localparam int COMMAND_LIMIT = 47185920;
	localparam int CORDIC_GAIN_Q30 = 652032874;
	localparam int CORDIC_STEPS = 17;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [2:0] {
		REG_OUTPUT_MODE   = 3'd0,
		REG_LATERAL_GAIN  = 3'd1,
		REG_HEADING_GAIN  = 3'd2,
		REG_LAT_RATE_GAIN = 3'd3,
		REG_FF_GAIN       = 3'd4,
		REG_TORQUE_GAIN   = 3'd5,
		REG_TORQUE_RATE   = 3'd6,
		REG_PREVIEW       = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_VALID    = 2'd0,
		ST_FAR      = 2'd1,
		ST_DISABLED = 2'd2,
		ST_LOADED   = 2'd3
	} res_code_t;

	typedef enum logic [3:0] {
		OP_NOP, OP_CAPTURE, OP_SCAN, OP_PREVIEW, OP_FETCH, OP_CORDIC, OP_MATH, OP_RESULT
	} op_t;

	// math sequence, at most one multiply issued per step, product used next step
	typedef enum logic [4:0] {
		M_FOLD = 5'd0, M_THETA, M_HEAD, M_LAT, M_STEER, M_ACC0, M_ACC1, M_ACC2, M_ACC3,
		M_DESIRED, M_OUT0, M_OUT1, M_OUT2, M_OUT3, M_OUT4
	} math_step_t;

	typedef struct packed {
		logic                  kind;
		logic [AW-1:0]         point_index;
		logic signed [47:0]    pos_x;
		logic signed [47:0]    pos_y;
		logic signed [18:0]    point_heading;
		logic signed [18:0]    point_steer;
		logic [24:0]           vehicle_heading;
		logic signed [26:0]    vehicle_steer;
	} item_t;

	typedef struct packed {
		logic signed [26:0] command;
		logic [1:0]         status;
		logic [AW-1:0]      nearest_point;
	} res_t;

	typedef struct packed {
		logic                  we;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		op_t           op;
		logic [AW-1:0] addr;
		logic          first;
		logic [4:0]    step;
		res_code_t     code;
	} cmd_t;

	typedef struct packed {
		logic        busy;
		logic        too_far;
		logic [AW:0] win_lo;
		logic [AW:0] win_hi;
	} stat_t;

	function automatic logic [15:0] atan_q16(input logic [4:0] i);
		case (i)
			5'd0: return 16'd51472;
			5'd1: return 16'd30386;
			5'd2: return 16'd16055;
			5'd3: return 16'd8150;
			5'd4: return 16'd4091;
			5'd5: return 16'd2047;
			5'd6: return 16'd1024;
			5'd7: return 16'd512;
			5'd8: return 16'd256;
			5'd9: return 16'd128;
			5'd10: return 16'd64;
			5'd11: return 16'd32;
			5'd12: return 16'd16;
			5'd13: return 16'd8;
			5'd14: return 16'd4;
			5'd15: return 16'd2;
			5'd16: return 16'd1;
			default: return 16'd0;
		endcase
	endfunction

	// divide by 2^s, half away from zero
	function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
			input int unsigned s);
		logic [63:0] m;
		logic [63:0] r;
		m = v[63] ? 64'(-v) : 64'(v);
		r = (m + (64'd1 << (s - 1))) >> s;
		return v[63] ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic signed [63:0] clamp_sym(input logic signed [63:0] v,
			input logic signed [63:0] lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	function automatic logic signed [19:0] wrap_angle(input logic signed [21:0] a);
		logic signed [21:0] t;
		t = a;
		for (int k = 0; k < 2; k++) begin
			if (t > PI_Q16)
				t = 22'(t - TWO_PI_Q16);
			else if (t < -PI_Q16)
				t = 22'(t + TWO_PI_Q16);
		end
		return t[19:0];
	endfunction

endpackage

// ===== rtl/psc_if.sv =====
interface psc_in_if;
	import psc_pkg::*;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [AW-1:0]      point_index;
	logic signed [47:0] pos_x;
	logic signed [47:0] pos_y;
	logic signed [18:0] point_heading;
	logic signed [18:0] point_steer;
	logic [24:0]        vehicle_heading;
	logic signed [26:0] vehicle_steer;
	modport source (output valid, kind, point_index, pos_x, pos_y, point_heading,
		point_steer, vehicle_heading, vehicle_steer, input ready);
	modport sink (input valid, kind, point_index, pos_x, pos_y, point_heading,
		point_steer, vehicle_heading, vehicle_steer, output ready);
endinterface

interface psc_out_if;
	import psc_pkg::*;
	logic               valid;
	logic               ready;
	logic signed [26:0] command;
	logic [1:0]         status;
	logic [AW-1:0]      nearest_point;
	modport source (output valid, command, status, nearest_point, input ready);
	modport sink (input valid, command, status, nearest_point, output ready);
endinterface

interface psc_cfg_if;
	import psc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/path_tracking_steer_controller.sv =====
// Path-tracking steering controller. Load beats (kind 0) store one path point
// (x, y, heading, reference steer) at point_index and answer status 3. Pose
// beats (kind 1) look for the nearest stored point: the first pose scans all
// 4096 entries, later poses scan from 500 points before the last match to
// 499 after it. If that first match lies farther than 3 m the block answers
// status 1 once and status 2 for every pose after it; a pose before any load
// also gets 2. Otherwise the point preview_offset entries ahead (held at the
// last entry) gives lateral and heading errors and a PD steer angle, and the
// answer is either a torque in N.m Q16 clamped to +-5 (output_mode 0) or the
// angle in degrees Q16 (output_mode 1). Every beat gives exactly one result
// beat. Timing: one item at a time. A pose scans N path points (4096 on the
// first pose, at most 1000 after) through the single read port of the path
// memory, which delivers one point per cycle; the tail is the 17-step CORDIC
// and 15 steps of a shared multiplier. The path memory has no reset and
// needs no clearing pass. Poses must only follow loads that cover every point
// they may read. Configuration writes are taken at any time but are only
// meant while idle.
module path_tracking_steer_controller import psc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	psc_in_if.sink    item,
	psc_out_if.source result,
	psc_cfg_if.sink   cfg
);
	item_t   item_d;
	cfg_wr_t cfg_d;
	cmd_t    cmd;
	stat_t   stat;
	res_t    res;

	assign item_d.kind = item.kind;
	assign item_d.point_index = item.point_index;
	assign item_d.pos_x = item.pos_x;
	assign item_d.pos_y = item.pos_y;
	assign item_d.point_heading = item.point_heading;
	assign item_d.point_steer = item.point_steer;
	assign item_d.vehicle_heading = item.vehicle_heading;
	assign item_d.vehicle_steer = item.vehicle_steer;

	// config channel always takes a beat
	assign cfg.ready = 1'b1;
	assign cfg_d.we = cfg.valid;
	assign cfg_d.idx = cfg.index;
	assign cfg_d.data = cfg.data;

	psc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_kind   (item.kind),
		.in_ready  (item.ready),
		.out_ready (result.ready),
		.out_valid (result.valid),
		.cmd       (cmd),
		.stat      (stat)
	);

	psc_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_d),
		.cfg    (cfg_d),
		.cmd    (cmd),
		.stat   (stat),
		.res    (res)
	);

	assign result.command = res.command;
	assign result.status = res.status;
	assign result.nearest_point = res.nearest_point;

	// an accepted beat always takes the block out of idle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> !item.ready)
		else $error("input taken while an item is in progress");

	// only a valid control result carries a nonzero command
	a_zero_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.status != ST_VALID) |-> (result.command == '0))
		else $error("nonzero command with non-valid status");

	// no new beat is taken while the path scan runs
	a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_SCAN) |-> !item.ready)
		else $error("input ready during a scan");
endmodule

// ===== rtl/psc_ram.sv =====
module psc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule

// ===== rtl/psc_ctrl.sv =====
module psc_ctrl import psc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  in_kind,
	output logic  in_ready,
	input  logic  out_ready,
	output logic  out_valid,
	output cmd_t  cmd,
	input  stat_t stat
);
	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_SCAN   = 9'b000000010,
		S_DRAIN  = 9'b000000100,
		S_CHECK  = 9'b000001000,
		S_PREV   = 9'b000010000,
		S_FETCH  = 9'b000100000,
		S_CORDIC = 9'b001000000,
		S_MATH   = 9'b010000000,
		S_DONE   = 9'b100000000
	} state_t;

	state_t    state_q, state_d;
	logic      loaded_q, first_done_q, start_good_q, out_valid_q;
	logic [AW:0] addr_q, lo_q, hi_q;
	logic [4:0]  cnt_q;
	res_code_t   code_q;
	logic [AW:0] addr_nx;

	assign addr_nx = addr_q + 1'b1;
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.op = OP_NOP;
		cmd.code = code_q;
		cmd.addr = addr_q[AW-1:0];
		cmd.first = (addr_q == lo_q);
		cmd.step = cnt_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = OP_CAPTURE;
					if (!in_kind || !loaded_q || (first_done_q && !start_good_q))
						state_d = S_DONE;
					else
						state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.op = OP_SCAN;
				if (addr_nx == hi_q)
					state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (!stat.busy)
					state_d = S_CHECK;
			end
			S_CHECK: begin
				state_d = (!first_done_q && stat.too_far) ? S_DONE : S_PREV;
			end
			S_PREV: begin
				cmd.op = OP_PREVIEW;
				state_d = S_FETCH;
			end
			S_FETCH: begin
				cmd.op = OP_FETCH;
				state_d = S_CORDIC;
			end
			S_CORDIC: begin
				cmd.op = OP_CORDIC;
				if (cnt_q == 5'(CORDIC_STEPS - 1))
					state_d = S_MATH;
			end
			S_MATH: begin
				cmd.op = OP_MATH;
				if (cnt_q == M_OUT4)
					state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.op = OP_RESULT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			loaded_q <= 1'b0;
			first_done_q <= 1'b0;
			start_good_q <= 1'b1;
			out_valid_q <= 1'b0;
			addr_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			cnt_q <= '0;
			code_q <= ST_LOADED;
		end else begin
			state_q <= state_d;
			if (cmd.op == OP_RESULT)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (!in_kind) begin
							loaded_q <= 1'b1;
							code_q <= ST_LOADED;
						end else if (!loaded_q || (first_done_q && !start_good_q)) begin
							code_q <= ST_DISABLED;
						end else if (!first_done_q) begin
							lo_q <= '0;
							addr_q <= '0;
							hi_q <= (AW+1)'(PATH_POINTS);
						end else begin
							lo_q <= stat.win_lo;
							addr_q <= stat.win_lo;
							hi_q <= stat.win_hi;
						end
					end
				end
				S_SCAN: addr_q <= addr_nx;
				S_CHECK: begin
					first_done_q <= 1'b1;
					cnt_q <= '0;
					if (!first_done_q && stat.too_far) begin
						start_good_q <= 1'b0;
						code_q <= ST_FAR;
					end
				end
				S_CORDIC: cnt_q <= (cnt_q == 5'(CORDIC_STEPS - 1)) ? 5'd0 : cnt_q + 1'b1;
				S_MATH: begin
					cnt_q <= cnt_q + 1'b1;
					code_q <= ST_VALID;
				end
				default: ;
			endcase
		end
	end
endmodule

// ===== rtl/psc_dp.sv =====
module psc_dp import psc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item,
	input  cfg_wr_t cfg,
	input  cmd_t    cmd,
	output stat_t   stat,
	output res_t    res
);
	// configuration
	logic        mode_q;
	logic [23:0] lg_q, hg_q, lrg_q, fg_q, tg_q, trg_q;
	logic [7:0]  po_q;

	// captured pose
	logic signed [47:0] x_q, y_q;
	logic [24:0]        vh_q;
	logic signed [26:0] vs_q;

	// path memory
	logic [MEM_W-1:0] rdata;
	logic             re;
	logic [AW-1:0]    raddr;
	logic signed [47:0] rx, ry;
	logic signed [18:0] rh, rs;

	// search pipeline
	logic          v_s1, v_s2, v_s3, first_s1, first_s2, first_s3;
	logic [AW-1:0] idx_s1, idx_s2, idx_s3;
	logic signed [31:0] dx_s2, dy_s2;
	logic [61:0]   sqx_s3, sqy_s3;
	logic [62:0]   best_q, sum;
	logic [AW-1:0] nearest_q;
	logic signed [63:0] sqx, sqy;

	// control law
	logic signed [31:0] dx_q, dy_q;
	logic signed [19:0] ref_q, ang_q, theta_q, he_q;
	logic signed [18:0] pst_q;
	logic signed [33:0] cx_q, cy_q, xs, ys;
	logic               flip_q;
	logic signed [17:0] c_q, s_q;
	logic signed [63:0] prod_q, acc_q;
	logic signed [33:0] lat_q, prev_lat_q;
	logic signed [22:0] steer_q;
	logic signed [31:0] desired_q, err_q, prev_err_q;
	logic signed [26:0] cmdv_q;
	logic signed [35:0] mul_a;
	logic signed [27:0] mul_b;
	res_t               res_q;

	logic [AW:0] near_ext, win_lo, win_hi, prev_sum;
	logic [AW-1:0] prev_idx;
	logic signed [19:0] h20, a_fold;
	logic               f_fold;
	logic signed [63:0] t64, r64;
	logic signed [63:0] cx_r, cy_r;

	function automatic logic signed [31:0] diff_clamp(input logic signed [47:0] a,
			input logic signed [47:0] b);
		logic signed [48:0] d;
		d = 49'(a) - 49'(b);
		if (d > 49'sd2147483647)
			return 32'sd2147483647;
		if (d < -49'sd2147483647)
			return -32'sd2147483647;
		return d[31:0];
	endfunction

	assign {rx, ry, rh, rs} = rdata;

	// window and preview address
	assign near_ext = {1'b0, nearest_q};
	assign win_lo = (near_ext > (AW+1)'(SEARCH_HALF_WINDOW)) ?
		near_ext - (AW+1)'(SEARCH_HALF_WINDOW) : '0;
	assign win_hi = ((near_ext + (AW+1)'(SEARCH_HALF_WINDOW)) > (AW+1)'(PATH_POINTS)) ?
		(AW+1)'(PATH_POINTS) : near_ext + (AW+1)'(SEARCH_HALF_WINDOW);
	assign prev_sum = near_ext + (AW+1)'(po_q);
	assign prev_idx = (prev_sum > (AW+1)'(PATH_POINTS - 1)) ?
		AW'(PATH_POINTS - 1) : prev_sum[AW-1:0];

	assign stat.busy = v_s1 | v_s2 | v_s3;
	assign stat.too_far = best_q > (63'd9 << 32);
	assign stat.win_lo = win_lo;
	assign stat.win_hi = win_hi;
	assign res = res_q;

	assign re = (cmd.op == OP_SCAN) || (cmd.op == OP_PREVIEW);
	assign raddr = (cmd.op == OP_SCAN) ? cmd.addr : prev_idx;

	psc_ram #(.WIDTH(MEM_W), .DEPTH(PATH_POINTS)) u_path (
		.clk   (clk),
		.we    ((cmd.op == OP_CAPTURE) && !item.kind),
		.waddr (item.point_index),
		.wdata ({item.pos_x, item.pos_y, item.point_heading, item.point_steer}),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign sqx = dx_s2 * dx_s2;
	assign sqy = dy_s2 * dy_s2;
	assign sum = {1'b0, sqx_s3} + {1'b0, sqy_s3};

	// heading wrap and quadrant fold ahead of the CORDIC
	always_comb begin
		h20 = wrap_angle(22'(rh));
		a_fold = h20;
		f_fold = 1'b0;
		if (h20 > HALF_PI_Q16) begin
			a_fold = 20'(h20 - PI_Q16);
			f_fold = 1'b1;
		end else if (h20 < -HALF_PI_Q16) begin
			a_fold = 20'(h20 + PI_Q16);
			f_fold = 1'b1;
		end
	end

	assign xs = cx_q >>> cmd.step;
	assign ys = cy_q >>> cmd.step;
	assign cx_r = clamp_sym(rnd_shift(64'(cx_q), 14), 64'sd65536);
	assign cy_r = clamp_sym(rnd_shift(64'(cy_q), 14), 64'sd65536);
	assign t64 = rnd_shift(prod_q, 32);
	assign r64 = rnd_shift(prod_q, 16);

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (cmd.op == OP_MATH) begin
			case (cmd.step)
				M_FOLD: begin
					mul_a = $signed({11'b0, vh_q});
					mul_b = 28'(DEG2RAD_Q32);
				end
				M_THETA: begin
					mul_a = 36'(dy_q);
					mul_b = 28'(c_q);
				end
				M_HEAD: begin
					mul_a = 36'(dx_q);
					mul_b = 28'(s_q);
				end
				M_LAT: begin
					mul_a = 36'(vs_q);
					mul_b = 28'(DEG2RAD_Q32);
				end
				M_STEER: begin
					mul_a = 36'(lat_q);
					mul_b = $signed({4'b0, lg_q});
				end
				M_ACC0: begin
					mul_a = 36'(he_q);
					mul_b = $signed({4'b0, hg_q});
				end
				M_ACC1: begin
					mul_a = 36'(pst_q);
					mul_b = $signed({4'b0, fg_q});
				end
				M_ACC2: begin
					mul_a = 36'(lat_q) - 36'(prev_lat_q);
					mul_b = $signed({4'b0, lrg_q});
				end
				M_OUT0: begin
					mul_a = 36'(desired_q);
					mul_b = 28'(RAD2DEG_Q16);
				end
				M_OUT1: begin
					mul_a = 36'(err_q);
					mul_b = $signed({4'b0, tg_q});
				end
				M_OUT2: begin
					mul_a = 36'(err_q) - 36'(prev_err_q);
					mul_b = $signed({4'b0, trg_q});
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			lg_q <= 24'd9830;
			hg_q <= 24'd163840;
			lrg_q <= 24'd655;
			fg_q <= 24'd65536;
			tg_q <= 24'd1966080;
			trg_q <= 24'd327680;
			po_q <= 8'd20;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			nearest_q <= '0;
			prev_lat_q <= '0;
			prev_err_q <= '0;
		end else begin
			if (cfg.we) begin
				case (cfg_reg_t'(cfg.idx))
					REG_OUTPUT_MODE:   mode_q <= cfg.data[0];
					REG_LATERAL_GAIN:  lg_q <= cfg.data;
					REG_HEADING_GAIN:  hg_q <= cfg.data;
					REG_LAT_RATE_GAIN: lrg_q <= cfg.data;
					REG_FF_GAIN:       fg_q <= cfg.data;
					REG_TORQUE_GAIN:   tg_q <= cfg.data;
					REG_TORQUE_RATE:   trg_q <= cfg.data;
					REG_PREVIEW:       po_q <= cfg.data[7:0];
					default: ;
				endcase
			end
			v_s1 <= (cmd.op == OP_SCAN);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3 && (first_s3 || sum < best_q))
				nearest_q <= idx_s3;
			if (cmd.op == OP_MATH && cmd.step == M_DESIRED)
				prev_lat_q <= lat_q;
			if (cmd.op == OP_MATH && cmd.step == M_OUT4 && !mode_q)
				prev_err_q <= err_q;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= cmd.addr;
		first_s1 <= cmd.first;
		idx_s2 <= idx_s1;
		first_s2 <= first_s1;
		dx_s2 <= diff_clamp(x_q, rx);
		dy_s2 <= diff_clamp(y_q, ry);
		idx_s3 <= idx_s2;
		first_s3 <= first_s2;
		sqx_s3 <= sqx[61:0];
		sqy_s3 <= sqy[61:0];
		if (v_s3 && (first_s3 || sum < best_q))
			best_q <= sum;
		prod_q <= mul_a * mul_b;

		case (cmd.op)
			OP_CAPTURE: begin
				x_q <= item.pos_x;
				y_q <= item.pos_y;
				vh_q <= item.vehicle_heading;
				vs_q <= item.vehicle_steer;
			end
			OP_FETCH: begin
				dx_q <= diff_clamp(x_q, rx);
				dy_q <= diff_clamp(y_q, ry);
				ref_q <= 20'(rh);
				pst_q <= rs;
				ang_q <= a_fold;
				flip_q <= f_fold;
				cx_q <= 34'(CORDIC_GAIN_Q30);
				cy_q <= '0;
			end
			OP_CORDIC: begin
				if (!ang_q[19]) begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					ang_q <= ang_q - $signed({4'b0, atan_q16(cmd.step)});
				end else begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					ang_q <= ang_q + $signed({4'b0, atan_q16(cmd.step)});
				end
			end
			OP_MATH: begin
				case (cmd.step)
					M_FOLD: begin
						c_q <= flip_q ? 18'(-cx_r) : 18'(cx_r);
						s_q <= flip_q ? 18'(-cy_r) : 18'(cy_r);
					end
					M_THETA: theta_q <= wrap_angle(22'(64'(HALF_PI_Q16) - t64));
					M_HEAD: begin
						he_q <= wrap_angle(22'(theta_q) - 22'(ref_q));
						acc_q <= prod_q;
					end
					M_LAT: lat_q <= 34'(rnd_shift(acc_q - prod_q, 16));
					M_STEER: steer_q <= 23'(t64);
					M_ACC0: acc_q <= prod_q;
					M_ACC1, M_ACC2, M_ACC3: acc_q <= acc_q + prod_q;
					M_DESIRED:
						desired_q <= 32'(clamp_sym(rnd_shift(acc_q, 16), 64'sd2147483647));
					M_OUT0: begin
						if (64'(desired_q) + TRIM_RAD_Q16 - 64'(steer_q) > 64'sd2147483647)
							err_q <= 32'sh7fffffff;
						else if (64'(desired_q) + TRIM_RAD_Q16 - 64'(steer_q) <
								-64'sd2147483648)
							err_q <= 32'sh80000000;
						else
							err_q <= 32'(64'(desired_q) + TRIM_RAD_Q16 - 64'(steer_q));
					end
					M_OUT1: begin
						if (mode_q)
							cmdv_q <= 27'(clamp_sym(r64 + TRIM_DEG_Q16, 64'(COMMAND_LIMIT)));
					end
					M_OUT2: acc_q <= -prod_q;
					M_OUT3: acc_q <= acc_q + prod_q;
					M_OUT4: begin
						if (!mode_q)
							cmdv_q <= 27'(clamp_sym(rnd_shift(acc_q, 16),
								64'(TORQUE_LIMIT)));
					end
					default: ;
				endcase
			end
			OP_RESULT: begin
				res_q.command <= (cmd.code == ST_VALID) ? cmdv_q : '0;
				res_q.status <= cmd.code;
				res_q.nearest_point <= nearest_q;
			end
			default: ;
		endcase
	end
endmodule
